[hdl/alt_pkg.sv]
package alt_pkg;

    localparam int SPACE_COUNT_BITS_DEF = 8;

    // result roles
    localparam logic [2:0] ROLE_DROP  = 3'd0;
    localparam logic [2:0] ROLE_LABEL = 3'd1;
    localparam logic [2:0] ROLE_INSTR = 3'd2;
    localparam logic [2:0] ROLE_PARM  = 3'd3;
    localparam logic [2:0] ROLE_CMNT  = 3'd4;

    // line kinds
    localparam logic [2:0] KIND_EMPTY     = 3'd0;
    localparam logic [2:0] KIND_ILLEGAL   = 3'd1;
    localparam logic [2:0] KIND_CMNT_ONLY = 3'd2;
    localparam logic [2:0] KIND_CMNT_IND  = 3'd3;
    localparam logic [2:0] KIND_EQUATE    = 3'd4;
    localparam logic [2:0] KIND_NORMAL    = 3'd5;

    localparam logic [3:0] PARAM_MAX = 4'd15;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_E      = 8'h45;
    localparam logic [7:0] CH_Q      = 8'h51;
    localparam logic [7:0] CH_U      = 8'h55;

    typedef struct packed {
        logic [7:0] char_code;
        logic       has_char;
        logic       line_end;
    } alt_in_t;

    typedef struct packed {
        logic [2:0] role;
        logic [7:0] out_char;
        logic [7:0] spaces_before;
        logic [3:0] param_index;
        logic       line_done;
        logic [2:0] line_kind;
        logic       label_had_colon;
    } alt_out_t;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        logic [7:0] u;
        u = to_upper(c);
        return (u >= 8'h41 && u <= 8'h5A) || (u >= 8'h30 && u <= 8'h39) ||
               u == 8'h2E || u == 8'h5F;
    endfunction

endpackage

[hdl/asm_line_tokenizer.sv]
// Latency: a result is presented the cycle after its character beat is accepted.
// Throughput: one character per cycle while m_ready is high; the scan state
// update is a single combinational step from accepted beat to result register.
// Reset: synchronous, active low; clears the scan state and empties the result
// register. The scan state also returns to its initial value after each line end.
module asm_line_tokenizer #(
    parameter int SPACE_COUNT_BITS = alt_pkg::SPACE_COUNT_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  alt_pkg::alt_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output alt_pkg::alt_out_t m_data
);
    import alt_pkg::*;

    localparam int HW = (SPACE_COUNT_BITS > 8) ? SPACE_COUNT_BITS : 8;
    localparam logic [SPACE_COUNT_BITS-1:0] HELD_MAX = '1;

    typedef enum logic [3:0] {
        ST_INIT, ST_COMMENT, ST_LABEL, ST_COLON, ST_BEFORE_INSTR, ST_INSTR,
        ST_AFTER_INSTR, ST_PARM, ST_SQ_PARM, ST_DQ_PARM, ST_BEFORE_COMMA,
        ST_AFTER_COMMA, ST_ERR
    } scan_state_t;

    typedef enum logic [2:0] {
        IM_EMPTY, IM_EQUALS, IM_E, IM_EQ, IM_EQU, IM_OTHER
    } instr_match_t;

    typedef enum logic [1:0] {
        TC_NORMAL, TC_ONLY, TC_INDENTED
    } typed_comment_t;

    scan_state_t                 scan_state_reg, scan_state_next;
    instr_match_t                instr_match_reg, instr_match_next;
    typed_comment_t              typed_comment_reg, typed_comment_next;
    logic                        label_seen_reg, label_seen_next;
    logic                        label_bad_reg, label_bad_next;
    logic                        instr_bad_reg, instr_bad_next;
    logic                        colon_seen_reg, colon_seen_next;
    logic [3:0]                  param_count_reg, param_count_next;
    logic [SPACE_COUNT_BITS-1:0] held_spaces_reg, held_spaces_next;
    logic                        m_valid_reg;
    alt_out_t                    m_data_reg, m_data_next;
    logic                        s_accept;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    function automatic logic [7:0] sat_spaces(input logic [SPACE_COUNT_BITS-1:0] h);
        logic [HW-1:0] w;
        w = HW'(h);
        return (w > HW'(255)) ? 8'hFF : w[7:0];
    endfunction

    always_comb begin
        logic [7:0] c;
        logic [7:0] u;
        logic       skip;
        logic [2:0] kind;
        logic [3:0] count;

        scan_state_next    = scan_state_reg;
        instr_match_next   = instr_match_reg;
        typed_comment_next = typed_comment_reg;
        label_seen_next    = label_seen_reg;
        label_bad_next     = label_bad_reg;
        instr_bad_next     = instr_bad_reg;
        colon_seen_next    = colon_seen_reg;
        param_count_next   = param_count_reg;
        held_spaces_next   = held_spaces_reg;
        m_data_next        = '0;

        c     = s_data.char_code;
        u     = to_upper(c);
        skip  = 1'b0;
        kind  = KIND_NORMAL;
        count = '0;

        if (s_data.has_char) begin
            // pending colon: space or NUL makes it a terminator
            if (scan_state_next == ST_COLON) begin
                if (c == CH_SPACE || c == CH_NUL) begin
                    colon_seen_next = 1'b1;
                    scan_state_next = ST_BEFORE_INSTR;
                end else begin
                    scan_state_next = ST_ERR;
                    skip = 1'b1;
                end
            end
            if (!skip) begin
                unique case (scan_state_next)
                    ST_INIT: begin
                        if (c == CH_SEMI) begin
                            scan_state_next    = ST_COMMENT;
                            typed_comment_next = TC_ONLY;
                        end else if (c == CH_SPACE) begin
                            scan_state_next = ST_BEFORE_INSTR;
                        end else if (c == CH_COLON) begin
                            scan_state_next = ST_ERR;
                        end else begin
                            scan_state_next = ST_LABEL;
                            label_seen_next = 1'b1;
                            if (!is_ident(c)) label_bad_next = 1'b1;
                            m_data_next.role     = ROLE_LABEL;
                            m_data_next.out_char = c;
                        end
                    end
                    ST_COMMENT: begin
                        m_data_next.role     = ROLE_CMNT;
                        m_data_next.out_char = c;
                    end
                    ST_LABEL: begin
                        if (c == CH_SEMI) scan_state_next = ST_COMMENT;
                        else if (c == CH_SPACE) scan_state_next = ST_BEFORE_INSTR;
                        else if (c == CH_COLON) scan_state_next = ST_COLON;
                        else begin
                            label_seen_next = 1'b1;
                            if (!is_ident(c)) label_bad_next = 1'b1;
                            m_data_next.role     = ROLE_LABEL;
                            m_data_next.out_char = c;
                        end
                    end
                    ST_BEFORE_INSTR, ST_INSTR: begin
                        if (c == CH_SEMI) begin
                            if (scan_state_next == ST_BEFORE_INSTR && !label_seen_next)
                                typed_comment_next = TC_INDENTED;
                            scan_state_next = ST_COMMENT;
                        end else if (c == CH_SPACE) begin
                            if (scan_state_next == ST_INSTR)
                                scan_state_next = ST_AFTER_INSTR;
                        end else begin
                            scan_state_next = ST_INSTR;
                            if (!is_ident(c)) instr_bad_next = 1'b1;
                            // track an "=", "E", "EQ", "EQU" prefix
                            case (instr_match_next)
                                IM_EMPTY: instr_match_next = (u == CH_EQUALS) ? IM_EQUALS :
                                                             (u == CH_E) ? IM_E : IM_OTHER;
                                IM_E:     instr_match_next = (u == CH_Q) ? IM_EQ : IM_OTHER;
                                IM_EQ:    instr_match_next = (u == CH_U) ? IM_EQU : IM_OTHER;
                                default:  instr_match_next = IM_OTHER;
                            endcase
                            m_data_next.role     = ROLE_INSTR;
                            m_data_next.out_char = u;
                        end
                    end
                    ST_AFTER_INSTR, ST_AFTER_COMMA: begin
                        if (c == CH_SEMI && scan_state_next == ST_AFTER_INSTR) begin
                            scan_state_next = ST_COMMENT;
                        end else if (c == CH_COMMA && scan_state_next == ST_AFTER_COMMA) begin
                            scan_state_next = ST_ERR;
                        end else if (c != CH_SPACE) begin
                            held_spaces_next        = '0;
                            m_data_next.role        = ROLE_PARM;
                            m_data_next.out_char    = c;
                            m_data_next.param_index = param_count_next;
                            scan_state_next = (c == CH_SQUOTE) ? ST_SQ_PARM :
                                              (c == CH_DQUOTE) ? ST_DQ_PARM : ST_PARM;
                        end
                    end
                    ST_PARM: begin
                        if (c == CH_SEMI || c == CH_COMMA) begin
                            held_spaces_next = '0;
                            if (param_count_next != PARAM_MAX)
                                param_count_next = param_count_next + 4'd1;
                            scan_state_next = (c == CH_SEMI) ? ST_COMMENT : ST_AFTER_COMMA;
                        end else if (c == CH_SPACE) begin
                            // hold trailing spaces until the next kept character
                            if (held_spaces_next != HELD_MAX)
                                held_spaces_next = held_spaces_next + 1'b1;
                        end else begin
                            m_data_next.role          = ROLE_PARM;
                            m_data_next.out_char      = c;
                            m_data_next.spaces_before = sat_spaces(held_spaces_next);
                            m_data_next.param_index   = param_count_next;
                            held_spaces_next          = '0;
                        end
                    end
                    ST_SQ_PARM, ST_DQ_PARM: begin
                        m_data_next.role        = ROLE_PARM;
                        m_data_next.out_char    = c;
                        m_data_next.param_index = param_count_next;
                        if ((scan_state_next == ST_SQ_PARM && c == CH_SQUOTE) ||
                            (scan_state_next == ST_DQ_PARM && c == CH_DQUOTE)) begin
                            held_spaces_next = '0;
                            if (param_count_next != PARAM_MAX)
                                param_count_next = param_count_next + 4'd1;
                            scan_state_next = ST_BEFORE_COMMA;
                        end
                    end
                    ST_BEFORE_COMMA: begin
                        if (c == CH_SEMI) scan_state_next = ST_COMMENT;
                        else if (c == CH_COMMA) scan_state_next = ST_AFTER_COMMA;
                    end
                    default: ;
                endcase
            end
        end

        if (s_data.line_end) begin
            if (scan_state_next == ST_COLON) begin
                colon_seen_next = 1'b1;
                scan_state_next = ST_BEFORE_INSTR;
            end
            kind = (typed_comment_next == TC_ONLY) ? KIND_CMNT_ONLY :
                   (typed_comment_next == TC_INDENTED) ? KIND_CMNT_IND : KIND_NORMAL;
            count = param_count_next;
            if (label_bad_next) kind = KIND_ILLEGAL;
            if (instr_bad_next && instr_match_next != IM_EQUALS) kind = KIND_ILLEGAL;
            if (scan_state_next == ST_INIT) begin
                kind = KIND_EMPTY;
            end else if (scan_state_next == ST_BEFORE_INSTR && !label_seen_next) begin
                kind = KIND_EMPTY;
            end else if (scan_state_next == ST_ERR || scan_state_next == ST_AFTER_COMMA ||
                         scan_state_next == ST_SQ_PARM || scan_state_next == ST_DQ_PARM) begin
                kind = KIND_ILLEGAL;
            end else if (scan_state_next == ST_PARM && count != PARAM_MAX) begin
                count = count + 4'd1;
            end
            if (instr_match_next == IM_EQUALS || instr_match_next == IM_EQU) begin
                if (!label_seen_next || colon_seen_next || count != 4'd1)
                    kind = KIND_ILLEGAL;
                else
                    kind = KIND_EQUATE;
            end
            m_data_next.line_done       = 1'b1;
            m_data_next.line_kind       = kind;
            m_data_next.label_had_colon = colon_seen_next;

            // start the next line clean
            scan_state_next    = ST_INIT;
            instr_match_next   = IM_EMPTY;
            typed_comment_next = TC_NORMAL;
            label_seen_next    = 1'b0;
            label_bad_next     = 1'b0;
            instr_bad_next     = 1'b0;
            colon_seen_next    = 1'b0;
            param_count_next   = '0;
            held_spaces_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_state_reg    <= ST_INIT;
            instr_match_reg   <= IM_EMPTY;
            typed_comment_reg <= TC_NORMAL;
            label_seen_reg    <= 1'b0;
            label_bad_reg     <= 1'b0;
            instr_bad_reg     <= 1'b0;
            colon_seen_reg    <= 1'b0;
            param_count_reg   <= '0;
            held_spaces_reg   <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (s_accept) begin
                scan_state_reg    <= scan_state_next;
                instr_match_reg   <= instr_match_next;
                typed_comment_reg <= typed_comment_next;
                label_seen_reg    <= label_seen_next;
                label_bad_reg     <= label_bad_next;
                instr_bad_reg     <= instr_bad_next;
                colon_seen_reg    <= colon_seen_next;
                param_count_reg   <= param_count_next;
                held_spaces_reg   <= held_spaces_next;
                m_data_reg        <= m_data_next;
            end
            // load a new beat or drain the taken one
            if (s_ready) m_valid_reg <= s_valid;
        end
    end

endmodule

[test/tb.sv]
module tb;
    import alt_pkg::*;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_Z_UP  = 8'h5A;
    localparam logic [7:0] CH_Z_LO  = 8'h7A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CASE_BIT = 8'h20;

    typedef enum logic [3:0] {
        SC_INIT, SC_COMMENT, SC_LABEL, SC_COLON, SC_PRE_OP, SC_OP, SC_POST_OP,
        SC_ARG, SC_ARG_SQ, SC_ARG_DQ, SC_ARG_DONE, SC_POST_COMMA, SC_ERR
    } scan_t;

    typedef enum logic [2:0] {OP_NONE, OP_EQSIGN, OP_E, OP_EQ, OP_EQU, OP_OTHER} opmatch_t;
    typedef enum logic [1:0] {CM_NONE, CM_ONLY, CM_INDENT} cmt_t;

    logic     aclk;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    alt_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    alt_out_t m_data;

    asm_line_tokenizer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // line scanner state of the predictor
    scan_t      scan;
    logic       lbl_seen, lbl_bad, op_bad, colon_term;
    opmatch_t   op_seen;
    logic [3:0] arg_idx;
    logic [7:0] held_sp;
    cmt_t       cmt_kind;

    alt_out_t   pending_tokens[$];
    logic [7:0] line_buf[$];

    bit   src_gaps    = 1'b1;
    bit   sink_stalls = 1'b1;
    int   mismatches = 0;
    int   tokens_checked = 0;
    int   lines_checked = 0;
    int   chars_sent = 0;
    int   long_gaps_left = 2;
    logic [5:0] kinds_seen = '0;
    logic [4:0] roles_seen = '0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [7:0] upcase(input logic [7:0] c);
        if (c >= CH_A_LO && c <= CH_Z_LO)
            return c & ~CASE_BIT;
        return c;
    endfunction

    function automatic logic ident_ok(input logic [7:0] c);
        logic [7:0] u;
        u = upcase(c);
        return (u >= CH_A_UP && u <= CH_Z_UP) || (u >= CH_ZERO && u <= CH_NINE) ||
               u == CH_DOT || u == CH_UNDER;
    endfunction

    function automatic void clear_line();
        scan       = SC_INIT;
        lbl_seen   = 1'b0;
        lbl_bad    = 1'b0;
        op_bad     = 1'b0;
        op_seen    = OP_NONE;
        colon_term = 1'b0;
        arg_idx    = 4'd0;
        held_sp    = 8'd0;
        cmt_kind   = CM_NONE;
    endfunction

    function automatic alt_out_t beat_out(input logic [2:0] role, input logic [7:0] c,
                                          input logic [7:0] sp, input logic [3:0] idx);
        alt_out_t r;
        r = '0;
        r.role          = role;
        r.out_char      = c;
        r.spaces_before = sp;
        r.param_index   = idx;
        return r;
    endfunction

    function automatic alt_out_t label_beat(input logic [7:0] c);
        lbl_seen = 1'b1;
        if (!ident_ok(c))
            lbl_bad = 1'b1;
        return beat_out(ROLE_LABEL, c, 8'd0, 4'd0);
    endfunction

    function automatic alt_out_t opcode_beat(input logic [7:0] c);
        logic [7:0] u;
        u = upcase(c);
        if (!ident_ok(c))
            op_bad = 1'b1;
        // track whether the opcode so far spells "=" or EQU
        case (op_seen)
            OP_NONE: op_seen = (u == CH_EQUALS) ? OP_EQSIGN : (u == CH_E) ? OP_E : OP_OTHER;
            OP_E:    op_seen = (u == CH_Q) ? OP_EQ : OP_OTHER;
            OP_EQ:   op_seen = (u == CH_U) ? OP_EQU : OP_OTHER;
            default: op_seen = OP_OTHER;
        endcase
        return beat_out(ROLE_INSTR, u, 8'd0, 4'd0);
    endfunction

    function automatic alt_out_t open_arg(input logic [7:0] c);
        held_sp = 8'd0;
        scan = (c == CH_SQUOTE) ? SC_ARG_SQ : (c == CH_DQUOTE) ? SC_ARG_DQ : SC_ARG;
        return beat_out(ROLE_PARM, c, 8'd0, arg_idx);
    endfunction

    function automatic void close_arg();
        held_sp = 8'd0;
        if (arg_idx != PARAM_MAX)
            arg_idx++;
    endfunction

    function automatic logic [2:0] kind_of_line();
        logic [2:0] k;
        logic [3:0] n;
        k = (cmt_kind == CM_ONLY) ? KIND_CMNT_ONLY :
            (cmt_kind == CM_INDENT) ? KIND_CMNT_IND : KIND_NORMAL;
        n = arg_idx;
        if (lbl_bad)
            k = KIND_ILLEGAL;
        if (op_bad && op_seen != OP_EQSIGN)
            k = KIND_ILLEGAL;
        if (scan == SC_INIT)
            k = KIND_EMPTY;
        else if (scan == SC_PRE_OP && !lbl_seen)
            k = KIND_EMPTY;
        else if (scan == SC_ERR || scan == SC_POST_COMMA || scan == SC_ARG_SQ ||
                 scan == SC_ARG_DQ)
            k = KIND_ILLEGAL;
        else if (scan == SC_ARG && n != PARAM_MAX)
            n++;  // open unquoted parameter still counts
        if (op_seen == OP_EQSIGN || op_seen == OP_EQU)
            k = (!lbl_seen || colon_term || n != 4'd1) ? KIND_ILLEGAL : KIND_EQUATE;
        return k;
    endfunction

    function automatic alt_out_t tokenize_step(input alt_in_t b);
        alt_out_t   r;
        logic [7:0] c;
        logic       skip;
        r = '0;
        c = b.char_code;
        skip = 1'b0;
        if (b.has_char) begin
            // pending colon: a space or NUL makes it a terminator
            if (scan == SC_COLON) begin
                if (c == CH_SPACE || c == CH_NUL) begin
                    colon_term = 1'b1;
                    scan = SC_PRE_OP;
                end else begin
                    scan = SC_ERR;
                    skip = 1'b1;
                end
            end
            if (!skip) begin
                case (scan)
                    SC_INIT:
                        if (c == CH_SEMI) begin
                            scan = SC_COMMENT;
                            cmt_kind = CM_ONLY;
                        end else if (c == CH_SPACE) begin
                            scan = SC_PRE_OP;
                        end else if (c == CH_COLON) begin
                            scan = SC_ERR;
                        end else begin
                            scan = SC_LABEL;
                            r = label_beat(c);
                        end
                    SC_COMMENT:
                        r = beat_out(ROLE_CMNT, c, 8'd0, 4'd0);
                    SC_LABEL:
                        if (c == CH_SEMI)
                            scan = SC_COMMENT;
                        else if (c == CH_SPACE)
                            scan = SC_PRE_OP;
                        else if (c == CH_COLON)
                            scan = SC_COLON;
                        else
                            r = label_beat(c);
                    SC_PRE_OP:
                        if (c == CH_SEMI) begin
                            scan = SC_COMMENT;
                            if (!lbl_seen)
                                cmt_kind = CM_INDENT;
                        end else if (c != CH_SPACE) begin
                            scan = SC_OP;
                            r = opcode_beat(c);
                        end
                    SC_OP:
                        if (c == CH_SEMI)
                            scan = SC_COMMENT;
                        else if (c == CH_SPACE)
                            scan = SC_POST_OP;
                        else
                            r = opcode_beat(c);
                    SC_POST_OP:
                        if (c == CH_SEMI)
                            scan = SC_COMMENT;
                        else if (c != CH_SPACE)
                            r = open_arg(c);
                    SC_ARG:
                        if (c == CH_SEMI) begin
                            close_arg();
                            scan = SC_COMMENT;
                        end else if (c == CH_COMMA) begin
                            close_arg();
                            scan = SC_POST_COMMA;
                        end else if (c == CH_SPACE) begin
                            if (held_sp != 8'hFF)
                                held_sp++;
                        end else begin
                            r = beat_out(ROLE_PARM, c, held_sp, arg_idx);
                            held_sp = 8'd0;
                        end
                    SC_ARG_SQ, SC_ARG_DQ: begin
                        r = beat_out(ROLE_PARM, c, 8'd0, arg_idx);
                        if ((scan == SC_ARG_SQ && c == CH_SQUOTE) ||
                            (scan == SC_ARG_DQ && c == CH_DQUOTE)) begin
                            close_arg();
                            scan = SC_ARG_DONE;
                        end
                    end
                    SC_ARG_DONE:
                        if (c == CH_SEMI)
                            scan = SC_COMMENT;
                        else if (c == CH_COMMA)
                            scan = SC_POST_COMMA;
                    SC_POST_COMMA:
                        if (c == CH_COMMA)
                            scan = SC_ERR;
                        else if (c != CH_SPACE)
                            r = open_arg(c);
                    default: ;
                endcase
            end
        end
        if (b.line_end) begin
            if (scan == SC_COLON) begin
                colon_term = 1'b1;
                scan = SC_PRE_OP;
            end
            r.line_done       = 1'b1;
            r.line_kind       = kind_of_line();
            r.label_had_colon = colon_term;
            clear_line();
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 50)
            $display("mismatch in %s at token %0d: got %0d, want %0d",
                     what, tokens_checked, got, want);
    endtask

    always @(posedge aclk) begin
        alt_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                pending_tokens.insert(pending_tokens.size(), tokenize_step(s_data));
            if (m_valid && m_ready) begin
                if (pending_tokens.size() == 0) begin
                    report_mismatch("unexpected token", 1, 0);
                end else begin
                    want = pending_tokens.pop_front();
                    if (m_data.role !== want.role)
                        report_mismatch("role", m_data.role, want.role);
                    if (m_data.out_char !== want.out_char)
                        report_mismatch("out_char", m_data.out_char, want.out_char);
                    if (m_data.spaces_before !== want.spaces_before)
                        report_mismatch("spaces_before", m_data.spaces_before,
                                        want.spaces_before);
                    if (m_data.param_index !== want.param_index)
                        report_mismatch("param_index", m_data.param_index, want.param_index);
                    if (m_data.line_done !== want.line_done)
                        report_mismatch("line_done", m_data.line_done, want.line_done);
                    if (m_data.line_kind !== want.line_kind)
                        report_mismatch("line_kind", m_data.line_kind, want.line_kind);
                    if (m_data.label_had_colon !== want.label_had_colon)
                        report_mismatch("label_had_colon", m_data.label_had_colon,
                                        want.label_had_colon);
                    roles_seen[want.role] = 1'b1;
                    if (want.line_done) begin
                        kinds_seen[want.line_kind] = 1'b1;
                        lines_checked++;
                    end
                end
                tokens_checked++;
            end
        end
    end

    // result side back-pressure
    initial begin
        int n;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (sink_stalls && $urandom_range(0, 2) == 0) begin
                n = $urandom_range(1, 10);
                m_ready <= 1'b0;
            end else begin
                n = $urandom_range(1, 20);
                m_ready <= 1'b1;
            end
            repeat (n) @(posedge aclk);
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic send_beat(input logic [7:0] c, input logic has, input logic fin);
        alt_in_t b;
        int      n;
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 10);
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        b.char_code = c;
        b.has_char  = has;
        b.line_end  = fin;
        s_valid <= 1'b1;
        s_data  <= b;
        do
            @(posedge aclk);
        while (!s_ready);
        if (has || fin)
            chars_sent++;
    endtask

    task automatic send_line(input bit end_alone);
        int i;
        for (i = 0; i < line_buf.size(); i++) begin
            // sprinkle beats that carry neither a character nor an end
            if ($urandom_range(0, 30) == 0)
                send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_beat(line_buf[i], 1'b1, !end_alone && i == line_buf.size() - 1);
        end
        if (end_alone || line_buf.size() == 0)
            send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        line_buf.delete();
    endtask

    task automatic buf_add(input logic [7:0] c);
        line_buf.insert(line_buf.size(), c);
    endtask

    task automatic queue_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            buf_add(s[i]);
    endtask

    task automatic push_spaces(input int n);
        repeat (n) buf_add(CH_SPACE);
    endtask

    function automatic logic [7:0] ident_char();
        case ($urandom_range(0, 4))
            0: return CH_A_LO + 8'($urandom_range(0, 25));
            1: return CH_ZERO + 8'($urandom_range(0, 9));
            2: return ($urandom_range(0, 1) != 0) ? CH_DOT : CH_UNDER;
            default: return CH_A_UP + 8'($urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == CH_SPACE || c == CH_COMMA || c == CH_SEMI)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] syntax_char();
        case ($urandom_range(0, 7))
            0: return CH_SPACE;
            1: return CH_COLON;
            2: return CH_SEMI;
            3: return CH_COMMA;
            4: return CH_SQUOTE;
            5: return CH_DQUOTE;
            6: return CH_NUL;
            default: return CH_EQUALS;
        endcase
    endfunction

    task automatic push_word(input int n);
        int i;
        for (i = 0; i < n; i++)
            buf_add(($urandom_range(0, 14) == 0) ? word_char() : ident_char());
    endtask

    task automatic push_comment();
        int k;
        buf_add(CH_SEMI);
        k = $urandom_range(0, 8);
        repeat (k) buf_add(8'($urandom_range(0, 255)));
    endtask

    task automatic build_random_line();
        int         pick, n_args, i, k;
        logic       equ_form;
        logic [7:0] q;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            // raw noise, biased toward the characters that steer the scanner
            k = $urandom_range(1, 12);
            repeat (k)
                buf_add(($urandom_range(0, 1) != 0) ?
                        8'($urandom_range(0, 255)) : syntax_char());
        end else if (pick == 1) begin
            push_comment();
        end else if (pick == 2) begin
            push_spaces($urandom_range(1, 4));
            if ($urandom_range(0, 1) != 0)
                push_comment();
        end else begin
            equ_form = (pick < 6);
            if (equ_form || $urandom_range(0, 3) != 0) begin
                push_word($urandom_range(1, 8));
                if ($urandom_range(0, equ_form ? 7 : 2) == 0) begin
                    buf_add(CH_COLON);
                    k = $urandom_range(0, 9);
                    if (k == 0)
                        buf_add(ident_char());
                    else if (k == 1)
                        buf_add(CH_NUL);
                end
            end
            push_spaces($urandom_range(1, 3));
            n_args = 0;
            if (equ_form) begin
                if ($urandom_range(0, 1) != 0) begin
                    buf_add(CH_EQUALS);
                end else begin
                    buf_add(($urandom_range(0, 1) != 0) ? CH_E : CH_E | CASE_BIT);
                    buf_add(($urandom_range(0, 1) != 0) ? CH_Q : CH_Q | CASE_BIT);
                    buf_add(($urandom_range(0, 1) != 0) ? CH_U : CH_U | CASE_BIT);
                end
                n_args = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : 1;
            end else if ($urandom_range(0, 9) != 0) begin
                push_word($urandom_range(1, 6));
                n_args = ($urandom_range(0, 29) == 0) ? $urandom_range(14, 18) :
                                                        $urandom_range(0, 4);
            end
            for (i = 0; i < n_args; i++) begin
                push_spaces((i == 0) ? $urandom_range(1, 2) : $urandom_range(0, 1));
                if ($urandom_range(0, 3) == 0) begin
                    q = ($urandom_range(0, 1) != 0) ? CH_SQUOTE : CH_DQUOTE;
                    buf_add(q);
                    k = $urandom_range(0, 6);
                    repeat (k)
                        buf_add(($urandom_range(0, 1) != 0) ? syntax_char() : word_char());
                    // leave the last quote open now and then
                    if (i != n_args - 1 || $urandom_range(0, 11) != 0)
                        buf_add(q);
                end else begin
                    buf_add(word_char());
                    k = $urandom_range(0, 6);
                    repeat (k)
                        buf_add(($urandom_range(0, 2) == 0) ? CH_SPACE : word_char());
                    if (long_gaps_left > 0 && $urandom_range(0, 60) == 0) begin
                        push_spaces($urandom_range(250, 300));
                        buf_add(word_char());
                        long_gaps_left--;
                    end
                end
                push_spaces($urandom_range(0, 2));
                if (i != n_args - 1) begin
                    buf_add(CH_COMMA);
                    if ($urandom_range(0, 29) == 0)
                        buf_add(CH_COMMA);
                end else if ($urandom_range(0, 24) == 0) begin
                    buf_add(CH_COMMA);
                end
            end
            if ($urandom_range(0, 2) == 0) begin
                push_spaces($urandom_range(0, 2));
                push_comment();
            end
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed_lines();
        send_beat(8'h00, 1'b0, 1'b1);          // line with no character at all
        send_beat(8'hFF, 1'b0, 1'b0);          // no character and no end: ignored
        queue_text(":");
        send_line(1'b0);                       // colon first on the line
        queue_text("A:");
        send_line(1'b0);                       // colon settled by the line end
        queue_text("B:Z");
        send_line(1'b0);                       // colon followed by a letter
        queue_text("C:");
        buf_add(CH_NUL);                       // NUL after the colon makes it a terminator
        queue_text("x");
        send_line(1'b1);
        queue_text("; ");
        send_line(1'b0);
        queue_text(" ;x");
        send_line(1'b0);
        queue_text("V = 9");
        send_line(1'b0);
        queue_text(" x 'a");
        send_line(1'b0);                       // quote left open
        queue_text(" y a,");
        send_line(1'b1);                       // dangling comma
    endtask

    task automatic test_long_operands();
        int i;
        // held spaces saturate in the report
        queue_text(" LD A");
        push_spaces($urandom_range(256, 270));
        buf_add(word_char());
        send_line(1'b0);
        // parameter index saturates
        queue_text(" DB ");
        for (i = 0; i < 18; i++) begin
            buf_add(ident_char());
            if (i < 17)
                buf_add(CH_COMMA);
        end
        send_line(1'b1);
    endtask

    task automatic test_random_lines(input int n_chars, input bit allow_idle);
        int start;
        start = chars_sent;
        while (chars_sent - start < n_chars) begin
            src_gaps    = allow_idle && ($urandom_range(0, 3) != 0);
            sink_stalls = allow_idle && ($urandom_range(0, 3) != 0);
            build_random_line();
            send_line($urandom_range(0, 3) == 0);
        end
    endtask

    initial begin
        clear_line();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_lines();
        test_long_operands();
        test_random_lines(950, 1'b1);
        test_random_lines(250, 1'b0);
        s_valid <= 1'b0;
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        @(posedge aclk);
        while (pending_tokens.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        $display("checked %0d tokens over %0d lines from %0d character beats",
                 tokens_checked, lines_checked, chars_sent);
        $display("line kinds seen %b, roles seen %b", kinds_seen, roles_seen);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d tokens still pending", pending_tokens.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
